>>> rtl/palr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared constants, types and tables of the path arc length resampler.
// No dependencies; every other file but palr_ram imports this package.
package palr_pkg;

    localparam int MAX_WAYPOINTS = 64;
    localparam int MAX_HORIZON   = 32;

    localparam int WP_AW   = $clog2(MAX_WAYPOINTS);
    localparam int CNT_W   = $clog2(MAX_WAYPOINTS + 1);
    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int LEN_W   = 33;
    localparam int SQ_W    = 2 * LEN_W;
    localparam int DIST_W  = 38 + WP_AW;
    localparam int STEP_W  = 31;
    localparam int HL_W    = 6;
    localparam int HEAD_W  = 16;
    localparam int CX_W    = 46;
    localparam int Z_W     = 20;
    localparam int CFG_IDX_W = 2;

    localparam int CORDIC_STEPS = 17;
    localparam int HALF_PI_Q16  = 102944;
    localparam int HEAD_LIMIT   = 25736;
    localparam int NORM_BIT     = 40;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_DISTANCE  = 2'd0,
        CFG_HORIZON_LENGTH = 2'd1
    } t_cfg_idx;

    // atan(2^-i) in Q16 radians
    function automatic logic [16:0] atan_q16(input logic [4:0] i);
        logic [16:0] a;
        unique case (i)
            5'd0:    a = 17'd51472;
            5'd1:    a = 17'd30386;
            5'd2:    a = 17'd16055;
            5'd3:    a = 17'd8150;
            5'd4:    a = 17'd4091;
            5'd5:    a = 17'd2047;
            5'd6:    a = 17'd1024;
            5'd7:    a = 17'd512;
            5'd8:    a = 17'd256;
            5'd9:    a = 17'd128;
            5'd10:   a = 17'd64;
            5'd11:   a = 17'd32;
            5'd12:   a = 17'd16;
            5'd13:   a = 17'd8;
            5'd14:   a = 17'd4;
            5'd15:   a = 17'd2;
            5'd16:   a = 17'd1;
            default: a = 17'd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

>>> rtl/palr_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channels: waypoint input and reference point output.
// Depends on palr_pkg.
interface palr_pt_if
    import palr_pkg::*;
;
    logic   valid;
    logic   ready;
    t_coord point_x;
    t_coord point_y;
    logic   path_end;

    modport source (output valid, point_x, point_y, path_end, input ready);
    modport sink   (input valid, point_x, point_y, path_end, output ready);
endinterface

interface palr_ref_if
    import palr_pkg::*;
;
    logic              valid;
    logic              ready;
    t_coord            ref_x;
    t_coord            ref_y;
    logic [HEAD_W-1:0] ref_heading;
    logic              ref_last;

    modport source (output valid, ref_x, ref_y, ref_heading, ref_last, input ready);
    modport sink   (input valid, ref_x, ref_y, ref_heading, ref_last, output ready);
endinterface
`default_nettype wire

>>> rtl/palr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic single write port RAM with one registered read port.
// No dependencies.
module palr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/palr_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on palr_pkg.
module palr_sqrt
    import palr_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [SQ_W-1:0] i_rad,
    output logic                 o_done,
    output logic [LEN_W-1:0]     o_root
);
    logic              r_busy;
    logic [5:0]        r_cnt;
    logic [SQ_W-1:0]   r_rad;
    logic [LEN_W+2:0]  r_rem;
    logic [LEN_W+2:0]  t_val;
    logic [LEN_W+2:0]  t_trial;

    assign t_val   = {r_rem[LEN_W:0], r_rad[SQ_W-1 -: 2]};
    assign t_trial = {1'b0, o_root, 2'b01};

    // one root bit per step, radicand consumed two bits at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(LEN_W - 1);
                r_rad  <= i_rad;
                r_rem  <= '0;
                o_root <= '0;
            end else if (r_busy) begin
                r_rad <= r_rad << 2;
                if (t_val >= t_trial) begin
                    r_rem  <= t_val - t_trial;
                    o_root <= {o_root[LEN_W-2:0], 1'b1};
                end else begin
                    r_rem  <= t_val;
                    o_root <= {o_root[LEN_W-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/palr_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle; quotient known to fit LEN_W bits.
// Depends on palr_pkg.
module palr_div
    import palr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SQ_W-1:0]  i_num,
    input  wire logic [LEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [LEN_W-1:0]      o_quo
);
    logic             r_busy;
    logic [6:0]       r_cnt;
    logic [SQ_W-1:0]  r_num;
    logic [LEN_W-1:0] r_den;
    logic [LEN_W-1:0] r_rem;
    logic [LEN_W:0]   t_val;

    assign t_val = {r_rem, r_num[SQ_W-1]};

    // shift in one numerator bit, subtract when it fits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(SQ_W - 1);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                o_quo  <= '0;
            end else if (r_busy) begin
                r_num <= r_num << 1;
                if (t_val >= {1'b0, r_den}) begin
                    r_rem <= LEN_W'(t_val - {1'b0, r_den});
                    o_quo <= {o_quo[LEN_W-2:0], 1'b1};
                end else begin
                    r_rem <= LEN_W'(t_val);
                    o_quo <= {o_quo[LEN_W-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
                r_cnt <= r_cnt - 7'd1;
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/palr_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// Iterative CORDIC vectoring unit: heading of a chord in Q2.13 radians.
// Depends on palr_pkg.
module palr_cordic
    import palr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire t_diff             i_dx,
    input  wire t_diff             i_dy,
    output logic                   o_done,
    output logic [HEAD_W-1:0]      o_heading
);
    typedef enum logic [1:0] {C_IDLE, C_NORM, C_ROT, C_ITER} t_cstate;

    t_cstate                 r_state;
    logic signed [CX_W-1:0]  r_x;
    logic signed [CX_W-1:0]  r_y;
    logic signed [Z_W-1:0]   r_z;
    logic [NORM_BIT:0]       r_m;
    logic [4:0]              r_i;
    logic [DIFF_W-1:0]       t_ax;
    logic [DIFF_W-1:0]       t_ay;
    logic signed [CX_W-1:0]  t_xs;
    logic signed [CX_W-1:0]  t_ys;
    logic signed [Z_W-1:0]   t_ang;
    logic signed [Z_W-1:0]   t_zr;
    logic signed [Z_W-1:0]   t_h;

    assign t_ax  = i_dx[DIFF_W-1] ? DIFF_W'(-i_dx) : DIFF_W'(i_dx);
    assign t_ay  = i_dy[DIFF_W-1] ? DIFF_W'(-i_dy) : DIFF_W'(i_dy);
    assign t_xs  = r_x >>> r_i;
    assign t_ys  = r_y >>> r_i;
    assign t_ang = Z_W'(atan_q16(r_i));
    assign t_zr  = (r_y > 0) ? r_z + t_ang : r_z - t_ang;
    assign t_h   = (t_zr + Z_W'(4)) >>> 3;

    // normalize, fold into the right half plane, then iterate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        if (i_dx == '0 && i_dy == '0) begin
                            o_heading <= '0;
                            o_done    <= 1'b1;
                        end else begin
                            r_m     <= (NORM_BIT+1)'((t_ax > t_ay) ? t_ax : t_ay);
                            r_x     <= CX_W'(i_dx);
                            r_y     <= CX_W'(i_dy);
                            r_state <= C_NORM;
                        end
                    end
                end
                C_NORM: begin
                    if (!r_m[NORM_BIT]) begin
                        r_m <= r_m << 1;
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end else begin
                        r_state <= C_ROT;
                    end
                end
                C_ROT: begin
                    r_i <= '0;
                    if (r_x < 0) begin
                        if (r_y >= 0) begin
                            r_x <= r_y;
                            r_y <= -r_x;
                            r_z <= Z_W'(HALF_PI_Q16);
                        end else begin
                            r_x <= -r_y;
                            r_y <= r_x;
                            r_z <= -Z_W'(HALF_PI_Q16);
                        end
                    end else begin
                        r_z <= '0;
                    end
                    r_state <= C_ITER;
                end
                C_ITER: begin
                    if (r_y > 0) begin
                        r_x <= r_x + t_ys;
                        r_y <= r_y - t_xs;
                    end else begin
                        r_x <= r_x - t_ys;
                        r_y <= r_y + t_xs;
                    end
                    r_z <= t_zr;
                    r_i <= r_i + 5'd1;
                    if (r_i == 5'(CORDIC_STEPS - 1)) begin
                        if (t_h > Z_W'(HEAD_LIMIT)) begin
                            o_heading <= HEAD_W'(HEAD_LIMIT);
                        end else if (t_h < -Z_W'(HEAD_LIMIT)) begin
                            o_heading <= HEAD_W'(-HEAD_LIMIT);
                        end else begin
                            o_heading <= HEAD_W'(t_h);
                        end
                        o_done  <= 1'b1;
                        r_state <= C_IDLE;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/path_arc_length_resampler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Path arc length resampler top level.
// Timing: waypoints are stored as they arrive; after the path end transfer each
// segment needs a square root and each reference point up to two divides and a
// CORDIC heading, all run on the shared iterative units.
// Throughput: one path at a time; input is not ready until the last point leaves.
// Reset: synchronous active low; clears control state and sets the config registers to their defaults.
module path_arc_length_resampler_top
    import palr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    palr_pt_if.sink                   i_pt,
    palr_ref_if.source                o_ref,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [STEP_W-1:0]    i_cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_START, S_SEG_RD, S_SEG_WT, S_SQX, S_SQY, S_SQS, S_SQRT,
        S_FIND, S_AMUL, S_ADIV, S_AWAIT, S_GOT, S_HEAD, S_HWAIT, S_OUT
    } t_state;

    t_state              r_state;
    logic [STEP_W-1:0]   r_step;
    logic [HL_W-1:0]     r_hl;
    logic [HL_W-1:0]     r_hl_eff;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_n;
    logic [CNT_W-1:0]    r_idx;
    logic [HL_W-1:0]     r_k;
    logic [DIST_W-1:0]   r_cur;
    logic [DIST_W-1:0]   r_tgt;
    logic [LEN_W-1:0]    r_len;
    logic [LEN_W-1:0]    r_rem;
    logic                r_seg_ok;
    logic                r_axis;
    logic                r_final;
    t_coord              r_first_x, r_first_y, r_last_x, r_last_y;
    t_coord              r_p0_x, r_p0_y, r_p1_x, r_p1_y;
    t_coord              r_np_x, r_np_y, r_pt_x, r_pt_y;
    t_diff               r_cdx, r_cdy;
    logic [HEAD_W-1:0]   r_head;
    logic [SQ_W-1:0]     r_prod;
    logic [SQ_W-1:0]     r_sq;

    logic                t_in_xfer;
    logic                t_out_xfer;
    logic                t_store;
    logic [2*COORD_W-1:0] t_rdata;
    logic [CNT_W-1:0]    t_rd_idx;
    t_diff               t_dx, t_dy;
    logic [LEN_W-1:0]    t_adx, t_ady;
    logic [LEN_W-1:0]    t_mul_a, t_mul_b;
    logic [DIST_W-1:0]   t_reach;
    logic [HL_W:0]       t_hl_wide;
    logic                t_sq_done, t_div_done, t_cd_done;
    logic [LEN_W-1:0]    t_root, t_quo;
    logic [HEAD_W-1:0]   t_heading;
    t_coord              t_along;
    t_coord              t_p0_sel;
    logic                t_neg;

    assign t_in_xfer  = i_pt.valid && i_pt.ready;
    assign t_out_xfer = o_ref.valid && o_ref.ready;
    assign t_store    = t_in_xfer && (r_count < CNT_W'(MAX_WAYPOINTS));
    assign i_pt.ready = (r_state == S_IDLE);
    assign t_rd_idx   = r_idx + CNT_W'(1);

    // current segment chord and magnitudes
    assign t_dx  = DIFF_W'(r_p1_x) - DIFF_W'(r_p0_x);
    assign t_dy  = DIFF_W'(r_p1_y) - DIFF_W'(r_p0_y);
    assign t_adx = t_dx[DIFF_W-1] ? LEN_W'(-t_dx) : LEN_W'(t_dx);
    assign t_ady = t_dy[DIFF_W-1] ? LEN_W'(-t_dy) : LEN_W'(t_dy);
    assign t_reach = r_cur + DIST_W'(r_len);
    assign t_hl_wide = {1'b0, r_hl};

    // step along the chosen axis by the divided offset
    assign t_neg    = r_axis ? t_dy[DIFF_W-1] : t_dx[DIFF_W-1];
    assign t_p0_sel = r_axis ? r_p0_y : r_p0_x;
    assign t_along  = t_neg ? t_p0_sel - COORD_W'(t_quo) : t_p0_sel + COORD_W'(t_quo);

    // shared multiplier operand select
    always_comb begin
        unique case (r_state)
            S_SQX: begin
                t_mul_a = t_adx;
                t_mul_b = t_adx;
            end
            S_SQY: begin
                t_mul_a = t_ady;
                t_mul_b = t_ady;
            end
            default: begin
                t_mul_a = r_rem;
                t_mul_b = r_axis ? t_ady : t_adx;
            end
        endcase
    end

    // hold the product for the next step
    always_ff @(posedge i_clk) begin
        r_prod <= t_mul_a * t_mul_b;
    end

    palr_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (MAX_WAYPOINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (t_store),
        .i_waddr (r_count[WP_AW-1:0]),
        .i_wdata ({i_pt.point_x, i_pt.point_y}),
        .i_raddr (t_rd_idx[WP_AW-1:0]),
        .o_rdata (t_rdata)
    );

    palr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SQS),
        .i_rad   (r_sq + r_prod),
        .o_done  (t_sq_done),
        .o_root  (t_root)
    );

    palr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_ADIV),
        .i_num   (r_prod),
        .i_den   (r_len),
        .o_done  (t_div_done),
        .o_quo   (t_quo)
    );

    palr_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == S_HEAD),
        .i_dx      (r_cdx),
        .i_dy      (r_cdy),
        .o_done    (t_cd_done),
        .o_heading (t_heading)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_W'(65536);
            r_hl   <= HL_W'(32);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_STEP_DISTANCE) begin
                r_step <= i_cfg_data;
            end else if (i_cfg_idx == CFG_HORIZON_LENGTH) begin
                r_hl <= i_cfg_data[HL_W-1:0];
            end
        end
    end

    // sequencer: load waypoints, walk segments, emit points
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            o_ref.valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (t_in_xfer) begin
                        if (t_store) begin
                            r_count  <= r_count + CNT_W'(1);
                            r_last_x <= i_pt.point_x;
                            r_last_y <= i_pt.point_y;
                            if (r_count == '0) begin
                                r_first_x <= i_pt.point_x;
                                r_first_y <= i_pt.point_y;
                            end
                        end
                        if (i_pt.path_end) begin
                            r_n     <= t_store ? r_count + CNT_W'(1) : r_count;
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_idx    <= '0;
                    r_cur    <= '0;
                    r_tgt    <= '0;
                    r_k      <= '0;
                    r_seg_ok <= 1'b0;
                    r_p0_x   <= r_first_x;
                    r_p0_y   <= r_first_y;
                    if (r_hl == '0) begin
                        r_hl_eff <= HL_W'(1);
                    end else if (t_hl_wide > (HL_W+1)'(MAX_HORIZON)) begin
                        r_hl_eff <= HL_W'(MAX_HORIZON);
                    end else begin
                        r_hl_eff <= r_hl;
                    end
                    r_state <= S_FIND;
                end
                S_SEG_RD: r_state <= S_SEG_WT;
                S_SEG_WT: begin
                    r_p1_x  <= t_rdata[2*COORD_W-1:COORD_W];
                    r_p1_y  <= t_rdata[COORD_W-1:0];
                    r_state <= S_SQX;
                end
                S_SQX: r_state <= S_SQY;
                S_SQY: begin
                    r_sq    <= r_prod;
                    r_state <= S_SQS;
                end
                S_SQS: r_state <= S_SQRT;
                S_SQRT: begin
                    if (t_sq_done) begin
                        r_len    <= t_root;
                        r_seg_ok <= 1'b1;
                        r_state  <= S_FIND;
                    end
                end
                S_FIND: begin
                    if (t_rd_idx < r_n) begin
                        if (!r_seg_ok) begin
                            r_state <= S_SEG_RD;
                        end else if (t_reach >= r_tgt) begin
                            r_rem <= LEN_W'(r_tgt - r_cur);
                            if (r_len == '0) begin
                                r_np_x  <= r_p0_x;
                                r_np_y  <= r_p0_y;
                                r_state <= S_GOT;
                            end else begin
                                r_axis  <= 1'b0;
                                r_state <= S_AMUL;
                            end
                        end else begin
                            r_cur    <= t_reach;
                            r_idx    <= t_rd_idx;
                            r_p0_x   <= r_p1_x;
                            r_p0_y   <= r_p1_y;
                            r_seg_ok <= 1'b0;
                        end
                    end else begin
                        r_np_x  <= r_last_x;
                        r_np_y  <= r_last_y;
                        r_state <= S_GOT;
                    end
                end
                S_AMUL: r_state <= S_ADIV;
                S_ADIV: r_state <= S_AWAIT;
                S_AWAIT: begin
                    if (t_div_done) begin
                        if (!r_axis) begin
                            r_np_x  <= t_along;
                            r_axis  <= 1'b1;
                            r_state <= S_AMUL;
                        end else begin
                            r_np_y  <= t_along;
                            r_state <= S_GOT;
                        end
                    end
                end
                S_GOT: begin
                    if (r_k == '0) begin
                        r_pt_x <= r_np_x;
                        r_pt_y <= r_np_y;
                        if (r_hl_eff == HL_W'(1)) begin
                            r_cdx   <= DIFF_W'(r_last_x) - DIFF_W'(r_first_x);
                            r_cdy   <= DIFF_W'(r_last_y) - DIFF_W'(r_first_y);
                            r_final <= 1'b1;
                            r_state <= S_HEAD;
                        end else begin
                            r_k     <= HL_W'(1);
                            r_tgt   <= r_tgt + DIST_W'(r_step);
                            r_state <= S_FIND;
                        end
                    end else begin
                        r_cdx   <= DIFF_W'(r_np_x) - DIFF_W'(r_pt_x);
                        r_cdy   <= DIFF_W'(r_np_y) - DIFF_W'(r_pt_y);
                        r_final <= 1'b0;
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: r_state <= S_HWAIT;
                S_HWAIT: begin
                    if (t_cd_done) begin
                        r_head            <= t_heading;
                        o_ref.ref_x       <= r_pt_x;
                        o_ref.ref_y       <= r_pt_y;
                        o_ref.ref_heading <= t_heading;
                        o_ref.ref_last    <= r_final;
                        o_ref.valid       <= 1'b1;
                        r_state           <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (t_out_xfer) begin
                        if (r_final) begin
                            o_ref.valid <= 1'b0;
                            r_count     <= '0;
                            r_state     <= S_IDLE;
                        end else if (r_k == r_hl_eff - HL_W'(1)) begin
                            // last point repeats the previous heading
                            o_ref.ref_x       <= r_np_x;
                            o_ref.ref_y       <= r_np_y;
                            o_ref.ref_heading <= r_head;
                            o_ref.ref_last    <= 1'b1;
                            r_final           <= 1'b1;
                        end else begin
                            o_ref.valid <= 1'b0;
                            r_pt_x      <= r_np_x;
                            r_pt_y      <= r_np_y;
                            r_k         <= r_k + HL_W'(1);
                            r_tgt       <= r_tgt + DIST_W'(r_step);
                            r_state     <= S_FIND;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
